### sv/hrbe_pkg.sv
// ----------------------------------------------------------------------------
// hrbe_pkg
// Shared types and constants for the HTTP response body extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package hrbe_pkg;

	localparam int LengthWidth = 32;

	localparam int NameLen  = 14;
	localparam int PosWidth = 5;
	localparam logic [PosWidth-1:0] DigitPos = PosWidth'(16);
	localparam logic [PosWidth-1:0] PosIdle  = PosWidth'(31);

	localparam logic [8*NameLen-1:0] HdrName = "Content-Length";

	localparam logic [7:0] ChLf    = 8'h0a;
	localparam logic [7:0] ChCr    = 8'h0d;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_BODY   = 2'd1,
		PH_DONE   = 2'd2,
		PH_ERROR  = 2'd3
	} phase_t;

	typedef enum logic {
		KIND_BODY  = 1'b0,
		KIND_ERROR = 1'b1
	} item_kind_t;

	typedef struct packed {
		item_kind_t kind;
		logic [7:0] data;
		logic       last;
	} item_t;

	function automatic logic [7:0] name_char(input logic [3:0] pos);
		name_char = HdrName[8*(NameLen-1-int'(pos)) +: 8];
	endfunction

endpackage

`default_nettype wire

### sv/hrbe_front.sv
// ----------------------------------------------------------------------------
// hrbe_front
// Header parser: classifies each accepted beat as dropped, body or error.
// ----------------------------------------------------------------------------
`default_nettype none

module hrbe_front
	import hrbe_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] rx_byte,
	input  wire logic       restart,
	output item_t           push_item,
	output logic            push
);

	phase_t                   phase_q, phase_d, phase_e;
	logic [PosWidth-1:0]      pos_q, pos_d, pos_e;
	logic [1:0]               lbc_q, lbc_d, lbc_e;
	logic                     cr_q, cr_d, cr_e;
	logic                     dig_q, dig_d, dig_e;
	logic [LengthWidth-1:0]   len_q, len_d, len_e;
	logic [LengthWidth-1:0]   rem_q, rem_d, rem_e;
	logic [LengthWidth-1:0]   rem_dec;
	logic [LengthWidth+3:0]   len_wide;
	logic [LengthWidth-1:0]   len_next;
	logic                     is_digit;
	logic                     hdr_end;

	assign phase_e = restart ? PH_HEADER : phase_q;
	assign pos_e   = restart ? '0 : pos_q;
	assign lbc_e   = restart ? '0 : lbc_q;
	assign cr_e    = restart ? 1'b0 : cr_q;
	assign dig_e   = restart ? 1'b0 : dig_q;
	assign len_e   = restart ? '0 : len_q;
	assign rem_e   = restart ? '0 : rem_q;

	assign is_digit = (rx_byte >= ChZero) && (rx_byte <= ChNine);
	assign len_wide = ({4'b0, len_e} << 3) + ({4'b0, len_e} << 1)
		+ {{(LengthWidth){1'b0}}, rx_byte[3:0]};
	assign len_next = (len_wide[LengthWidth+3:LengthWidth] != 4'b0) ?
		{LengthWidth{1'b1}} : len_wide[LengthWidth-1:0];
	assign hdr_end  = (lbc_e == 2'd1) && cr_e;
	assign rem_dec  = (rem_e != '0) ? rem_e - LengthWidth'(1) : '0;

	// next state
	always_comb begin
		phase_d = phase_e;
		pos_d   = pos_e;
		lbc_d   = lbc_e;
		cr_d    = cr_e;
		dig_d   = dig_e;
		len_d   = len_e;
		rem_d   = rem_e;
		unique case (phase_e)
			PH_HEADER: begin
				if (rx_byte == ChLf) begin
					lbc_d = '0;
					cr_d  = 1'b0;
					dig_d = 1'b0;
					pos_d = (len_e == '0) ? '0 : PosIdle;
					if (hdr_end) begin
						if (len_e == '0) begin
							phase_d = PH_ERROR;
						end else begin
							phase_d = PH_BODY;
							rem_d   = len_e;
						end
					end
				end else begin
					if (pos_e < PosWidth'(NameLen)) begin
						pos_d = (rx_byte == name_char(pos_e[3:0])) ?
							pos_e + PosWidth'(1) : PosIdle;
					end else if (pos_e < DigitPos) begin
						pos_d = pos_e + PosWidth'(1);
						if (pos_e + PosWidth'(1) == DigitPos) begin
							dig_d = 1'b1;
						end
					end else if (pos_e == DigitPos && dig_e) begin
						if (is_digit) begin
							len_d = len_next;
						end else begin
							dig_d = 1'b0;
							pos_d = PosIdle;
						end
					end else begin
						pos_d = PosIdle;
						dig_d = 1'b0;
					end
					if (lbc_e != 2'd3) begin
						lbc_d = lbc_e + 2'd1;
					end
					cr_d = (rx_byte == ChCr);
				end
			end
			PH_BODY: begin
				rem_d = rem_dec;
				if (rem_dec == '0) begin
					phase_d = PH_DONE;
				end
			end
			default: begin
			end
		endcase
	end

	// outputs
	always_comb begin
		push           = 1'b0;
		push_item.kind = KIND_BODY;
		push_item.data = rx_byte;
		push_item.last = (rem_dec == '0);
		unique case (phase_e)
			PH_HEADER: begin
				if (rx_byte == ChLf && hdr_end && len_e == '0) begin
					push           = accept;
					push_item.kind = KIND_ERROR;
				end
			end
			PH_BODY: begin
				push = accept;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q   <= '0;
			lbc_q   <= '0;
			cr_q    <= 1'b0;
			dig_q   <= 1'b0;
			len_q   <= '0;
			rem_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			lbc_q   <= lbc_d;
			cr_q    <= cr_d;
			dig_q   <= dig_d;
			len_q   <= len_d;
			rem_q   <= rem_d;
		end
	end

endmodule

`default_nettype wire

### sv/hrbe_queue.sv
// ----------------------------------------------------------------------------
// hrbe_queue
// Two-entry queue between the parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module hrbe_queue
	import hrbe_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	output logic       not_full,
	input  wire logic  pop,
	output item_t      pop_item,
	output logic       not_empty
);

	item_t      mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign not_full  = (cnt_q != 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign pop_item  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### sv/hrbe_back.sv
// ----------------------------------------------------------------------------
// hrbe_back
// Output stage: formats queued items into result beats and holds them.
// ----------------------------------------------------------------------------
`default_nettype none

module hrbe_back
	import hrbe_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire item_t      q_item,
	input  wire logic       q_valid,
	output logic            q_pop,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      body_byte,
	output logic            last_of_body,
	output logic            error_flag
);

	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       err_q;

	assign q_pop        = q_valid && (!valid_q || out_ready);
	assign out_valid    = valid_q;
	assign body_byte    = byte_q;
	assign last_of_body = last_q;
	assign error_flag   = err_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			if (q_item.kind == KIND_ERROR) begin
				byte_q <= 8'h00;
				last_q <= 1'b0;
				err_q  <= 1'b1;
			end else begin
				byte_q <= q_item.data;
				last_q <= q_item.last;
				err_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

### sv/http_response_body_extractor.sv
// ----------------------------------------------------------------------------
// http_response_body_extractor
// Strips the header of an HTTP response and passes Content-Length body bytes.
// ----------------------------------------------------------------------------
// Input channel: one response byte per beat (rx_byte), with restart set on a
// beat to bring the parser back to the header phase before that byte.
// Output channel: one result per body byte (last_of_body marks the final
// byte of the Content-Length count), or a single error beat (error_flag set,
// body_byte zero) when the header ends without a nonzero length. Header
// bytes and bytes after the body or the error produce no beat.
// Path: a body byte passes the queue and then the output register. Throughput:
// one byte per cycle while in_ready is high; the parser updates its state in
// the accepting cycle and the length multiply-add fits that cycle.
// Stalls: a two-entry queue sits between the parser and the output register;
// in_ready drops only when that queue is full, so input keeps flowing while
// one result waits at the output.
// Reset: arst_n returns the parser to the header phase with zero length and
// empties the queue and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module http_response_body_extractor
	import hrbe_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	input  wire logic       restart,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      body_byte,
	output logic            last_of_body,
	output logic            error_flag
);

	item_t push_item;
	item_t pop_item;
	logic  push;
	logic  pop;
	logic  not_full;
	logic  not_empty;
	logic  accept;

	assign in_ready = not_full;
	assign accept   = in_valid && not_full;

	hrbe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.rx_byte   (rx_byte),
		.restart   (restart),
		.push_item (push_item),
		.push      (push)
	);

	hrbe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.not_full  (not_full),
		.pop       (pop),
		.pop_item  (pop_item),
		.not_empty (not_empty)
	);

	hrbe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_item       (pop_item),
		.q_valid      (not_empty),
		.q_pop        (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.body_byte    (body_byte),
		.last_of_body (last_of_body),
		.error_flag   (error_flag)
	);

endmodule

`default_nettype wire
